// ===== sv/cpf_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and command tables shared by the picture fetch sequencer.
// No dependencies.
package cpf_pkg;

    localparam int PACKET_BYTES_DEF  = 256;
    localparam int PAYLOAD_BYTES_DEF = 250;
    localparam int JOB_DEPTH         = 2;
    localparam int RES_DEPTH         = 2;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_CAM   = 2'd1;
    localparam logic [1:0] MODE_HOST  = 2'd2;

    localparam logic [1:0] TGT_CAM    = 2'd0;
    localparam logic [1:0] TGT_HOST   = 2'd1;
    localparam logic [1:0] TGT_STATUS = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_ACK = 3'd1;
    localparam logic [2:0] ST_BAD_HDR = 3'd2;
    localparam logic [2:0] ST_UNEXP   = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] ACK_ID    = 8'h0E;
    localparam logic [7:0] DATA_ID   = 8'h0A;
    localparam logic [7:0] DATA_SUB  = 8'h05;
    localparam logic [7:0] CHAR_K    = 8'h4B;
    localparam logic [7:0] CHAR_O    = 8'h4F;
    localparam logic [7:0] CC_INIT   = 8'h01;
    localparam logic [7:0] CC_PKG    = 8'h06;
    localparam logic [7:0] CC_PIC    = 8'h04;

    localparam logic [2:0] FRAME_LAST = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ACK_INIT,
        PH_ACK_PKG,
        PH_ACK_PIC,
        PH_HEADER,
        PH_WAIT_K,
        PH_PACKET,
        PH_WAIT_O,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        JOB_INITIAL,
        JOB_PKGSIZE,
        JOB_GETPIC,
        JOB_ACK,
        JOB_HEADER,
        JOB_BYTE,
        JOB_STATUS
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  status;
        logic [23:0] data;
    } job_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0] target;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } out_word_t;

    // Camera command frames, byte by byte.
    function automatic logic [7:0] cmd_byte(input job_kind_t kind, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            3'd0: b = SYNC_BYTE;
            3'd1:
            begin
                case (kind)
                    JOB_INITIAL: b = 8'h01;
                    JOB_PKGSIZE: b = 8'h06;
                    default:     b = 8'h04;
                endcase
            end
            3'd2:
            begin
                case (kind)
                    JOB_INITIAL: b = 8'h00;
                    JOB_PKGSIZE: b = 8'h08;
                    default:     b = 8'h05;
                endcase
            end
            3'd3: b = (kind == JOB_INITIAL) ? 8'h07 : 8'h00;
            3'd4:
            begin
                case (kind)
                    JOB_INITIAL: b = 8'h03;
                    JOB_PKGSIZE: b = 8'h01;
                    default:     b = 8'h00;
                endcase
            end
            3'd5: b = (kind == JOB_INITIAL) ? 8'h07 : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/cpf_fifo.sv =====
`timescale 1ns / 1ps
// Small first-word-fall-through queue on flops.
// No dependencies.
module cpf_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     data_in,
    output logic full,
    input  logic pop,
    output T     data_out,
    output logic empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= data_in;
    end

endmodule

// ===== sv/cpf_front.sv =====
`timescale 1ns / 1ps
// Front end: protocol phase tracking, acknowledge and header checks, packet
// bookkeeping. Emits at most one job per accepted word. Depends on cpf_pkg.
module cpf_front #(
    parameter int PACKET_BYTES  = cpf_pkg::PACKET_BYTES_DEF,
    parameter int PAYLOAD_BYTES = cpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  cpf_pkg::in_word_t item,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic              job_valid,
    output cpf_pkg::job_t     job
);
    import cpf_pkg::*;

    localparam int          IDXW    = $clog2(PACKET_BYTES + 1);
    localparam logic [23:0] PAYLOAD = 24'(PAYLOAD_BYTES);

    phase_t          phase_reg, phase_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic [16:0]     pkt_reg, pkt_next;
    logic [23:0]     rem_reg, rem_next;
    logic            match_reg, match_next;
    logic            cont_reg;

    logic [7:0]      b;
    logic [7:0]      cc;
    logic            bad_byte, match_new, six_end;
    logic [23:0]     hdr_size;
    logic            pkt_full;
    logic [IDXW-1:0] limit, idx_inc;
    logic [IDXW:0]   idx_plus2;
    logic            fwd_byte, pkt_end;
    logic [23:0]     rem_sub;
    logic            rem_sub_full;

    assign b = item.in_byte;

    always_comb
    begin
        case (phase_reg)
            PH_ACK_INIT: cc = CC_INIT;
            PH_ACK_PKG:  cc = CC_PKG;
            default:     cc = CC_PIC;
        endcase
    end

    // Per-position compare; byte 3 of an acknowledge is don't care.
    always_comb
    begin
        bad_byte = 1'b0;
        if (phase_reg == PH_HEADER)
        begin
            case (idx_reg)
                IDXW'(0): bad_byte = (b != SYNC_BYTE);
                IDXW'(1): bad_byte = (b != DATA_ID);
                IDXW'(2): bad_byte = (b != DATA_SUB);
                default:  bad_byte = 1'b0;
            endcase
        end
        else
        begin
            case (idx_reg)
                IDXW'(0): bad_byte = (b != SYNC_BYTE);
                IDXW'(1): bad_byte = (b != ACK_ID);
                IDXW'(2): bad_byte = (b != cc);
                IDXW'(4): bad_byte = (b != 8'h00);
                IDXW'(5): bad_byte = (b != 8'h00);
                default:  bad_byte = 1'b0;
            endcase
        end
    end

    assign match_new = match_reg && !bad_byte;
    assign six_end   = (idx_reg == IDXW'(FRAME_LAST));
    assign hdr_size  = {b, rem_reg[15:0]};

    assign pkt_full     = (rem_reg >= PAYLOAD);
    assign limit        = pkt_full ? IDXW'(PACKET_BYTES) : IDXW'(6) + IDXW'(rem_reg);
    assign idx_inc      = idx_reg + 1'b1;
    assign idx_plus2    = {1'b0, idx_reg} + (IDXW+1)'(2);
    assign fwd_byte     = (idx_reg >= IDXW'(4)) && (idx_plus2 < {1'b0, limit});
    assign pkt_end      = (idx_inc >= limit);
    assign rem_sub      = rem_reg - PAYLOAD;
    assign rem_sub_full = (rem_sub >= PAYLOAD);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (item.mode)
                MODE_START:
                begin
                    if (phase_reg == PH_IDLE || phase_reg == PH_ERROR)
                        phase_next = PH_ACK_INIT;
                end
                MODE_CAM:
                begin
                    case (phase_reg)
                        PH_ACK_INIT, PH_ACK_PKG, PH_ACK_PIC:
                        begin
                            if (six_end)
                            begin
                                if (!match_new)
                                    phase_next = PH_ERROR;
                                else if (phase_reg == PH_ACK_INIT)
                                    phase_next = PH_ACK_PKG;
                                else if (phase_reg == PH_ACK_PKG)
                                    phase_next = PH_ACK_PIC;
                                else
                                    phase_next = PH_HEADER;
                            end
                        end
                        PH_HEADER:
                        begin
                            if (six_end)
                                phase_next = match_new ? PH_WAIT_K : PH_ERROR;
                        end
                        PH_PACKET:
                        begin
                            if (pkt_end)
                            begin
                                if (pkt_full && (rem_sub_full || rem_sub != '0))
                                    phase_next = PH_PACKET;
                                else
                                    phase_next = PH_WAIT_O;
                            end
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
                MODE_HOST:
                begin
                    if (phase_reg == PH_WAIT_K)
                        phase_next = (!pkt_full && rem_reg == '0) ? PH_WAIT_O : PH_PACKET;
                    else if (phase_reg == PH_WAIT_O)
                        phase_next = cont_reg ? PH_ACK_PIC : PH_IDLE;
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Counters and job output
    always_comb
    begin
        idx_next   = idx_reg;
        pkt_next   = pkt_reg;
        rem_next   = rem_reg;
        match_next = match_reg;
        job_valid  = 1'b0;
        job.kind   = JOB_STATUS;
        job.status = ST_OK;
        job.data   = '0;
        if (accept)
        begin
            case (item.mode)
                MODE_START:
                begin
                    if (phase_reg == PH_IDLE || phase_reg == PH_ERROR)
                    begin
                        job_valid  = 1'b1;
                        job.kind   = JOB_INITIAL;
                        idx_next   = '0;
                        match_next = 1'b1;
                    end
                end
                MODE_CAM:
                begin
                    case (phase_reg)
                        PH_ACK_INIT, PH_ACK_PKG, PH_ACK_PIC:
                        begin
                            idx_next   = idx_inc;
                            match_next = match_new;
                            if (six_end)
                            begin
                                idx_next   = '0;
                                match_next = 1'b1;
                                if (!match_new)
                                begin
                                    job_valid  = 1'b1;
                                    job.kind   = JOB_STATUS;
                                    job.status = ST_BAD_ACK;
                                end
                                else if (phase_reg == PH_ACK_INIT)
                                begin
                                    job_valid = 1'b1;
                                    job.kind  = JOB_PKGSIZE;
                                end
                                else if (phase_reg == PH_ACK_PKG)
                                begin
                                    job_valid = 1'b1;
                                    job.kind  = JOB_GETPIC;
                                end
                            end
                        end
                        PH_HEADER:
                        begin
                            idx_next   = idx_inc;
                            match_next = match_new;
                            if (idx_reg == IDXW'(3))
                                rem_next[7:0] = b;
                            if (idx_reg == IDXW'(4))
                                rem_next[15:8] = b;
                            if (six_end)
                            begin
                                rem_next   = hdr_size;
                                idx_next   = '0;
                                match_next = 1'b1;
                                job_valid  = 1'b1;
                                if (match_new)
                                begin
                                    job.kind = JOB_HEADER;
                                    job.data = hdr_size;
                                end
                                else
                                begin
                                    job.kind   = JOB_STATUS;
                                    job.status = ST_BAD_HDR;
                                end
                            end
                        end
                        PH_PACKET:
                        begin
                            idx_next = idx_inc;
                            if (fwd_byte)
                            begin
                                job_valid = 1'b1;
                                job.kind  = JOB_BYTE;
                                job.data  = {16'h0000, b};
                            end
                            if (pkt_end)
                            begin
                                // next packet, or the extra acknowledge after the last one
                                idx_next  = '0;
                                job_valid = 1'b1;
                                job.kind  = JOB_ACK;
                                job.data  = 24'(pkt_reg + 1'b1);
                                if (pkt_full)
                                begin
                                    pkt_next = pkt_reg + 1'b1;
                                    rem_next = rem_sub;
                                end
                            end
                        end
                        default: idx_next = idx_reg;
                    endcase
                end
                MODE_HOST:
                begin
                    if (phase_reg == PH_WAIT_K)
                    begin
                        job_valid  = 1'b1;
                        job.kind   = JOB_ACK;
                        job.status = (b == CHAR_K) ? ST_OK : ST_UNEXP;
                        job.data   = '0;
                        pkt_next   = '0;
                        idx_next   = '0;
                    end
                    else if (phase_reg == PH_WAIT_O)
                    begin
                        job_valid  = 1'b1;
                        job.status = (b == CHAR_O) ? ST_DONE : ST_UNEXP;
                        idx_next   = '0;
                        if (cont_reg)
                        begin
                            job.kind   = JOB_GETPIC;
                            match_next = 1'b1;
                        end
                        else
                            job.kind = JOB_STATUS;
                    end
                end
                default: idx_next = idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            pkt_reg   <= '0;
            rem_reg   <= '0;
            match_reg <= 1'b1;
            cont_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            pkt_reg   <= pkt_next;
            rem_reg   <= rem_next;
            match_reg <= match_next;
            if (cfg_we)
                cont_reg <= cfg_data;
        end
    end

endmodule

// ===== sv/cpf_back.sv =====
`timescale 1ns / 1ps
// Back end: expands one job into its output words, one word per cycle
// while the result queue has room. Depends on cpf_pkg.
module cpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    input  cpf_pkg::job_t      job,
    output logic               job_pop,
    input  logic               res_full,
    output logic               res_push,
    output cpf_pkg::out_word_t res
);
    import cpf_pkg::*;

    logic [2:0] cnt_reg, cnt_next;
    logic       single;
    logic       is_last;

    assign single   = (job.kind == JOB_BYTE) || (job.kind == JOB_STATUS);
    assign is_last  = single || (cnt_reg == FRAME_LAST);
    assign res_push = !job_empty && !res_full;
    assign job_pop  = res_push && is_last;

    always_comb
    begin
        res.status   = job.status;
        res.last     = is_last;
        res.target   = TGT_CAM;
        res.out_byte = 8'h00;
        case (job.kind)
            JOB_INITIAL, JOB_PKGSIZE, JOB_GETPIC:
                res.out_byte = cmd_byte(job.kind, cnt_reg);
            JOB_ACK:
            begin
                case (cnt_reg)
                    3'd0:    res.out_byte = SYNC_BYTE;
                    3'd1:    res.out_byte = ACK_ID;
                    3'd4:    res.out_byte = job.data[7:0];
                    3'd5:    res.out_byte = job.data[15:8];
                    default: res.out_byte = 8'h00;
                endcase
            end
            JOB_HEADER:
            begin
                res.target = TGT_HOST;
                case (cnt_reg)
                    3'd0:    res.out_byte = SYNC_BYTE;
                    3'd1:    res.out_byte = DATA_ID;
                    3'd2:    res.out_byte = DATA_SUB;
                    3'd3:    res.out_byte = job.data[7:0];
                    3'd4:    res.out_byte = job.data[15:8];
                    default: res.out_byte = job.data[23:16];
                endcase
            end
            JOB_BYTE:
            begin
                res.target   = TGT_HOST;
                res.out_byte = job.data[7:0];
            end
            default:
                res.target = TGT_STATUS;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (res_push)
            cnt_next = is_last ? 3'd0 : cnt_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

// ===== sv/camera_picture_fetch_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the camera picture fetch sequencer.
// Depends on cpf_pkg, cpf_fifo, cpf_front, cpf_back.
//
// Channel   Handshake                 Word
// -------   -----------------------   ------------------------------------
// item      push / full               in_word_t  {mode, in_byte}
// result    pop / empty               out_word_t {target, out_byte, status, last}
// cfg       cfg_valid / cfg_ready     cfg_data: continuous mode bit
//
// A word is taken whenever full is low; the front end turns it into at most one
// job (command, acknowledge, header forward, data byte or status). A job drains
// at one result word per cycle while the result queue has room, paced by the
// back end's word counter. Reset is immediate: all queues empty, phase idle.
// full rises only when the job queue is full; a stalled result side fills the
// result queue, then the job queue, then pushes back on the input.
module camera_picture_fetch_sequencer #(
    parameter int PACKET_BYTES  = cpf_pkg::PACKET_BYTES_DEF,
    parameter int PAYLOAD_BYTES = cpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cpf_pkg::in_word_t  item,
    output logic               full,
    input  logic               pop,
    output cpf_pkg::out_word_t result,
    output logic               empty,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    output logic               cfg_ready
);
    import cpf_pkg::*;

    logic      accept;
    logic      job_valid;
    job_t      job_in, job_head;
    logic      job_empty, job_pop;
    logic      res_full, res_push;
    out_word_t res_word;

    // Config register is a single flop; always writable.
    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    cpf_front #(
        .PACKET_BYTES  (PACKET_BYTES),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job       (job_in)
    );

    // Job queue decouples classification from word generation.
    cpf_fifo #(
        .T     (job_t),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .data_in  (job_in),
        .full     (full),
        .pop      (job_pop),
        .data_out (job_head),
        .empty    (job_empty)
    );

    cpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_word)
    );

    // Result queue: two-entry first-word-fall-through queue.
    cpf_fifo #(
        .T     (out_word_t),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_word),
        .full     (res_full),
        .pop      (pop),
        .data_out (result),
        .empty    (empty)
    );

endmodule

// ===== sv/cpf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the picture fetch sequencer, bound to the top level.
// Depends on cpf_pkg and camera_picture_fetch_sequencer.
module cpf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pop,
    input logic               empty,
    input cpf_pkg::out_word_t result
);
    import cpf_pkg::*;

    a_status_word_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.target == TGT_STATUS) |-> (result.last && result.out_byte == 8'h00))
        else $error("status-only word not last or carries data");

    a_host_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.target == TGT_HOST) |-> (result.status == ST_OK))
        else $error("host word with non-ok status");

    a_no_bad_target: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.target != 2'd3))
        else $error("invalid target code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

endmodule

bind camera_picture_fetch_sequencer cpf_checker u_cpf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for camera_picture_fetch_sequencer.
// Depends on cpf_pkg and the sequencer RTL; holds its own fetch-sequence predictor.
module tb_top;
    import cpf_pkg::*;

    localparam int PKT_BYTES = 256;
    localparam int PAY_BYTES = 250;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic push;
    in_word_t item;
    logic full;
    logic pop;
    out_word_t result;
    logic empty;
    logic cfg_valid;
    logic cfg_data;
    logic cfg_ready;

    camera_picture_fetch_sequencer dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .item(item), .full(full),
        .pop(pop), .result(result), .empty(empty),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cfg_ready(cfg_ready)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer's registers.
    // ------------------------------------------------------------------
    phase_t      p_phase;
    int unsigned p_idx;
    int unsigned p_pkt;
    int unsigned p_full_pkts;
    int unsigned p_tail;
    int unsigned p_size;
    bit          p_match;
    bit          p_cont;

    out_word_t expected_words[$];
    out_word_t step_words[$];

    int errors;
    int cycles;

    // Camera command frames, byte by byte.
    const logic [7:0] INIT_FRAME[6] = '{8'hAA, 8'h01, 8'h00, 8'h07, 8'h03, 8'h07};
    const logic [7:0] PKG_FRAME[6]  = '{8'hAA, 8'h06, 8'h08, 8'h00, 8'h01, 8'h00};
    const logic [7:0] PIC_FRAME[6]  = '{8'hAA, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00};

    task automatic add_word(input logic [1:0] tgt, input logic [7:0] b);
        out_word_t w;
        w = '0;
        w.target = tgt;
        w.out_byte = b;
        if (step_words.size() < 6)
            step_words.push_back(w);
    endtask

    task automatic add_frame(input logic [7:0] f[6]);
        for (int i = 0; i < 6; i++)
            add_word(TGT_CAM, f[i]);
    endtask

    task automatic add_pkt_ack(input int unsigned n);
        add_word(TGT_CAM, SYNC_BYTE);
        add_word(TGT_CAM, ACK_ID);
        add_word(TGT_CAM, 8'h00);
        add_word(TGT_CAM, 8'h00);
        add_word(TGT_CAM, n[7:0]);
        add_word(TGT_CAM, n[15:8]);
    endtask

    function automatic int unsigned pkt_limit(input int unsigned n);
        return (n < p_full_pkts) ? PKT_BYTES : 6 + p_tail;
    endfunction

    task automatic open_pkt(input int unsigned n);
        p_pkt = n;
        p_idx = 0;
        add_pkt_ack(n);
        p_phase = (pkt_limit(n) == 6) ? PH_WAIT_O : PH_PACKET;
    endtask

    task automatic enter_six(input phase_t nxt);
        p_phase = nxt;
        p_idx = 0;
        p_match = 1'b1;
    endtask

    task automatic abort_fetch(input logic [2:0] code, inout logic [2:0] st);
        step_words.delete();
        add_word(TGT_STATUS, 8'h00);
        st = code;
        p_phase = PH_ERROR;
        p_idx = 0;
        p_match = 1'b1;
    endtask

    task automatic predictor_reset();
        p_phase = PH_IDLE;
        p_idx = 0;
        p_pkt = 0;
        p_full_pkts = 0;
        p_tail = 0;
        p_size = 0;
        p_match = 1'b1;
        p_cont = 1'b0;
    endtask

    // Advance the predictor by one input word; returns its results in step_words.
    task automatic predict_fetch(input in_word_t w);
        logic [2:0] st;
        logic [7:0] cc;
        logic [7:0] want;
        int unsigned lim;
        st = ST_OK;
        step_words.delete();
        if (w.mode == MODE_START)
        begin
            if (p_phase == PH_IDLE || p_phase == PH_ERROR)
            begin
                add_frame(INIT_FRAME);
                enter_six(PH_ACK_INIT);
            end
        end
        else if (w.mode == MODE_CAM)
        begin
            if (p_phase == PH_ACK_INIT || p_phase == PH_ACK_PKG || p_phase == PH_ACK_PIC)
            begin
                cc = (p_phase == PH_ACK_INIT) ? CC_INIT :
                     (p_phase == PH_ACK_PKG) ? CC_PKG : CC_PIC;
                case (p_idx)
                    0: want = SYNC_BYTE;
                    1: want = ACK_ID;
                    2: want = cc;
                    3: want = w.in_byte;   // don't care
                    default: want = 8'h00;
                endcase
                if (p_idx < 6 && w.in_byte != want)
                    p_match = 1'b0;
                p_idx++;
                if (p_idx >= 6)
                begin
                    if (!p_match)
                        abort_fetch(ST_BAD_ACK, st);
                    else if (p_phase == PH_ACK_INIT)
                    begin
                        add_frame(PKG_FRAME);
                        enter_six(PH_ACK_PKG);
                    end
                    else if (p_phase == PH_ACK_PKG)
                    begin
                        add_frame(PIC_FRAME);
                        enter_six(PH_ACK_PIC);
                    end
                    else
                    begin
                        enter_six(PH_HEADER);
                        p_size = 0;
                    end
                end
            end
            else if (p_phase == PH_HEADER)
            begin
                if (p_idx == 0 && w.in_byte != SYNC_BYTE) p_match = 1'b0;
                if (p_idx == 1 && w.in_byte != DATA_ID) p_match = 1'b0;
                if (p_idx == 2 && w.in_byte != DATA_SUB) p_match = 1'b0;
                if (p_idx >= 3 && p_idx < 6)
                    p_size |= int'(w.in_byte) << (8 * (p_idx - 3));
                p_idx++;
                if (p_idx >= 6)
                begin
                    if (!p_match)
                        abort_fetch(ST_BAD_HDR, st);
                    else
                    begin
                        p_size &= 32'hFFFFFF;
                        p_full_pkts = p_size / PAY_BYTES;
                        p_tail = p_size % PAY_BYTES;
                        add_word(TGT_HOST, SYNC_BYTE);
                        add_word(TGT_HOST, DATA_ID);
                        add_word(TGT_HOST, DATA_SUB);
                        add_word(TGT_HOST, p_size[7:0]);
                        add_word(TGT_HOST, p_size[15:8]);
                        add_word(TGT_HOST, p_size[23:16]);
                        p_phase = PH_WAIT_K;
                        p_idx = 0;
                        p_match = 1'b1;
                    end
                end
            end
            else if (p_phase == PH_PACKET)
            begin
                lim = pkt_limit(p_pkt);
                if (p_idx >= 4 && p_idx + 2 < lim)
                    add_word(TGT_HOST, w.in_byte);
                p_idx++;
                if (p_idx >= lim)
                begin
                    if (p_pkt < p_full_pkts)
                        open_pkt(p_pkt + 1);
                    else
                    begin
                        add_pkt_ack(p_full_pkts + 1);
                        p_phase = PH_WAIT_O;
                        p_idx = 0;
                    end
                end
            end
        end
        else if (w.mode == MODE_HOST)
        begin
            if (p_phase == PH_WAIT_K)
            begin
                if (w.in_byte != CHAR_K)
                    st = ST_UNEXP;
                open_pkt(0);
            end
            else if (p_phase == PH_WAIT_O)
            begin
                st = (w.in_byte == CHAR_O) ? ST_DONE : ST_UNEXP;
                if (p_cont)
                begin
                    add_frame(PIC_FRAME);
                    enter_six(PH_ACK_PIC);
                end
                else
                begin
                    add_word(TGT_STATUS, 8'h00);
                    p_phase = PH_IDLE;
                    p_idx = 0;
                end
            end
        end
        for (int k = 0; k < step_words.size(); k++)
        begin
            step_words[k].status = st;
            step_words[k].last = (k == step_words.size() - 1);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall pattern, compare at the rising edge.
    // ------------------------------------------------------------------
    int stall_mode;
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected result %p", result));
            else
            begin
                e = expected_words.pop_front();
                if (result.target !== e.target || result.out_byte !== e.out_byte
                    || result.status !== e.status || result.last !== e.last)
                    report_mismatch($sformatf("got %p want %p", result, e));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            case (stall_mode)
                0: pop <= 1'b1;                                  // no stall
                1: pop <= ($urandom_range(0, 3) != 0);
                2: pop <= ($urandom_range(0, 3) == 0);           // heavy stall
                default: pop <= (cycles % 7) < 4;                // periodic
            endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 2000 == 0)
            stall_mode = $urandom_range(0, 3);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("camera_picture_fetch_sequencer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    int burst_left;
    int items_sent;

    // One input word: random gap between bursts, then push until accepted.
    // push stays high into the next word of a burst; it drops only in gaps.
    task automatic send_word(input logic [1:0] m, input logic [7:0] b);
        in_word_t w;
        int gap;
        w.mode = m;
        w.in_byte = b;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_fetch(w);
        foreach (step_words[k])
            expected_words.push_back(step_words[k]);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_continuous(input bit v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        p_cont = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_ack(input logic [7:0] cc, input bit good);
        logic [7:0] a[6];
        int bad;
        a = '{SYNC_BYTE, ACK_ID, cc, 8'($urandom), 8'h00, 8'h00};
        if (!good)
        begin
            bad = $urandom_range(0, 4);
            if (bad == 3)
                bad = 5;
            a[bad] = a[bad] ^ 8'(1 << $urandom_range(0, 7));
        end
        foreach (a[i])
            send_word(MODE_CAM, a[i]);
    endtask

    // One picture from the header on; small sizes mostly.
    task automatic send_picture(input int unsigned sz, input bit hdr_ok, input bit host_ok);
        logic [7:0] h[6];
        int unsigned npk;
        int unsigned tl;
        h = '{SYNC_BYTE, DATA_ID, DATA_SUB, sz[7:0], sz[15:8], sz[23:16]};
        if (!hdr_ok)
            h[$urandom_range(0, 2)] ^= 8'h10;
        foreach (h[i])
            send_word(MODE_CAM, h[i]);
        if (!hdr_ok)
            return;
        send_word(MODE_HOST, host_ok ? CHAR_K : 8'($urandom));
        npk = sz / PAY_BYTES;
        tl = sz % PAY_BYTES;
        for (int p = 0; p <= npk; p++)
        begin
            if (p == npk && tl == 0)
                break;
            for (int i = 0; i < ((p < npk) ? PKT_BYTES : 6 + tl); i++)
                send_word(MODE_CAM, 8'($urandom));
        end
        send_word(MODE_HOST, host_ok ? CHAR_O : 8'($urandom));
    endtask

    task automatic fetch_session(input int unsigned sz, input int fault);
        send_word(MODE_START, 8'($urandom));
        send_ack(CC_INIT, fault != 1);
        if (fault == 1) return;
        send_ack(CC_PKG, 1'b1);
        send_ack(CC_PIC, fault != 2);
        if (fault == 2) return;
        send_picture(sz, fault != 3, fault != 4);
    endtask

    // Directed table: {mode, byte, check_first, first expected word}
    typedef struct {
        logic [1:0] m;
        logic [7:0] b;
        bit         chk;
        out_word_t  first;
    } dir_row_t;

    dir_row_t dir_rows[$];

    task automatic add_row(input logic [1:0] m, input logic [7:0] b, input bit chk,
                           input logic [1:0] t, input logic [7:0] ob, input logic [2:0] st);
        dir_row_t r;
        r.m = m;
        r.b = b;
        r.chk = chk;
        r.first = '{target: t, out_byte: ob, status: st, last: 1'b0};
        dir_rows.push_back(r);
    endtask

    initial
    begin
        int unsigned sz;
        int r;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        burst_left = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        predictor_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: stray words, start, bad ack (error), restart, a start while busy,
        // then an empty picture with wrong host replies.
        add_row(MODE_CAM, 8'hFF, 1'b0, TGT_CAM, 8'h00, ST_OK);
        add_row(MODE_HOST, 8'h00, 1'b0, TGT_CAM, 8'h00, ST_OK);
        add_row(2'd3, 8'hFF, 1'b0, TGT_CAM, 8'h00, ST_OK);
        add_row(MODE_START, 8'h00, 1'b1, TGT_CAM, SYNC_BYTE, ST_OK);
        add_row(MODE_CAM, 8'h00, 1'b0, TGT_CAM, 8'h00, ST_OK);     // bad sync
        for (int i = 0; i < 5; i++)
            add_row(MODE_CAM, 8'hFF, 1'b0, TGT_CAM, 8'h00, ST_OK);
        add_row(MODE_START, 8'hFF, 1'b1, TGT_CAM, SYNC_BYTE, ST_OK);
        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].m, dir_rows[i].b);
            if (dir_rows[i].chk && step_words.size() != 0
                && step_words[0] != dir_rows[i].first)
                report_mismatch("directed row prediction");
        end
        send_ack(CC_INIT, 1'b1);
        send_ack(CC_PKG, 1'b1);
        send_word(MODE_START, 8'h00);                  // ignored while busy
        send_ack(CC_PIC, 1'b1);
        send_picture(0, 1'b1, 1'b0);                   // zero size, bad replies

        write_continuous(1'b1);
        fetch_session(250, 0);                         // exact full packet
        send_ack(CC_PIC, 1'b0);                        // error exit
        write_continuous(1'b0);

        // Random sessions: mostly well formed, some faults and noise.
        while (items_sent < 350)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                write_continuous($urandom_range(0, 1));
            if (r == 1)
                send_word(2'($urandom), 8'($urandom));
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
            fetch_session(sz, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            if (p_cont && p_phase == PH_ACK_PIC)
            begin
                send_ack(CC_PIC, 1'b1);
                send_picture($urandom_range(0, 20), 1'b1, $urandom_range(0, 3) != 0);
            end
        end
        // Header with all-ones size field (error path keeps it short).
        send_word(MODE_START, 8'h00);
        send_ack(CC_INIT, 1'b1);
        send_ack(CC_PKG, 1'b1);
        send_ack(CC_PIC, 1'b1);
        send_word(MODE_CAM, SYNC_BYTE);
        send_word(MODE_CAM, 8'hFF);
        send_word(MODE_CAM, DATA_SUB);
        for (int i = 0; i < 3; i++)
            send_word(MODE_CAM, 8'hFF);

        drain_results();
        if (errors == 0)
            $display("camera_picture_fetch_sequencer: match");
        else
            $display("camera_picture_fetch_sequencer: mismatch");
        $finish;
    end

endmodule
